// ===== hdl/wtp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wtp_pkg
// Shared widths, register indexes and pipeline types of the window to target
// pixel map.
// ----------------------------------------------------------------------------
package wtp_pkg;

	localparam int CW  = 16;  // window coordinate, two's complement
	localparam int EW  = 14;  // image rectangle edge
	localparam int SW  = 15;  // image and target sizes
	localparam int OW  = 14;  // target pixel coordinate
	localparam int RIW = 3;   // register index

	localparam logic [RIW-1:0] REG_IMAGE_LEFT   = 3'd0;
	localparam logic [RIW-1:0] REG_IMAGE_TOP    = 3'd1;
	localparam logic [RIW-1:0] REG_IMAGE_WIDTH  = 3'd2;
	localparam logic [RIW-1:0] REG_IMAGE_HEIGHT = 3'd3;
	localparam logic [RIW-1:0] REG_TARGET_COLS  = 3'd4;
	localparam logic [RIW-1:0] REG_TARGET_ROWS  = 3'd5;

	// control that travels down the divider chain next to the operands
	typedef struct packed {
		logic valid;
		logic hit;
	} wtp_ctl_t;

	typedef struct packed {
		logic          hit;
		logic [OW-1:0] col;
		logic [OW-1:0] row;
	} wtp_result_t;

endpackage
`default_nettype wire

// ===== hdl/wtp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wtp_if
// Valid/ready channels: window point in, target pixel out.
// ----------------------------------------------------------------------------
interface wtp_point_if;
	logic                            valid;
	logic                            ready;
	logic signed [wtp_pkg::CW-1:0]   window_col;
	logic signed [wtp_pkg::CW-1:0]   window_row;

	modport source (output valid, output window_col, output window_row, input ready);
	modport sink   (input valid, input window_col, input window_row, output ready);
endinterface

interface wtp_pixel_if;
	logic                   valid;
	logic                   ready;
	logic                   hit;
	logic [wtp_pkg::OW-1:0] target_col;
	logic [wtp_pkg::OW-1:0] target_row;

	modport source (output valid, output hit, output target_col, output target_row,
		input ready);
	modport sink   (input valid, input hit, input target_col, input target_row,
		output ready);
endinterface
`default_nettype wire

// ===== hdl/wtp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wtp_front
// One axis: offset into the rectangle, range check, divisor and the
// offset * (target - 1) product that feeds the divider chain.
// ----------------------------------------------------------------------------
module wtp_front #(
	parameter int MAX_DIM = 16384
) (
	input  wire logic                                      clk,
	input  wire logic                                      en,
	input  wire logic signed [wtp_pkg::CW-1:0]             pos,
	input  wire logic        [wtp_pkg::EW-1:0]             origin,
	input  wire logic        [wtp_pkg::SW-1:0]             size,
	input  wire logic        [wtp_pkg::SW-1:0]             tgt,
	output logic                                           ok_s2,
	output logic             [wtp_pkg::SW-1:0]             rem_s2,
	output logic             [$clog2(MAX_DIM)-1:0]         word_s2,
	output logic             [wtp_pkg::SW-1:0]             div_s2
);
	import wtp_pkg::*;

	localparam int QW = $clog2(MAX_DIM);
	localparam int NW = SW + QW;

	logic [CW:0]   diff;
	logic [SW-1:0] sz;
	logic          in_range;
	logic [QW-1:0] tm1;
	logic          zero;
	logic [NW-1:0] prod;

	logic          ok_s1;
	logic [SW-1:0] local_s1;
	logic [QW-1:0] tm1_s1;
	logic [SW-1:0] div_s1;
	logic          zero_s1;

	always_comb begin
		diff     = {pos[CW-1], pos} - (CW+1)'(origin);
		sz       = (size == '0) ? SW'(1) : size;
		in_range = !diff[CW] && (diff[CW-1:0] < CW'(sz));
		if (32'(tgt) > MAX_DIM) begin
			tm1 = QW'(MAX_DIM - 1);
		end else if (tgt == '0) begin
			tm1 = '0;
		end else begin
			tm1 = QW'(tgt - SW'(1));
		end
		zero = (sz == SW'(1)) || (tgt <= SW'(1));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s1    <= in_range && (tgt != '0);
			local_s1 <= diff[SW-1:0];
			tm1_s1   <= tm1;
			// divisor of one keeps the chain well defined on the zero path
			div_s1   <= zero ? SW'(1) : SW'(sz - SW'(1));
			zero_s1  <= zero;
		end
	end

	assign prod = zero_s1 ? '0 : NW'(local_s1) * NW'(tm1_s1);

	// quotient stays below 2**QW, so the upper part already sits below the divisor
	always_ff @(posedge clk) begin
		if (en) begin
			ok_s2   <= ok_s1;
			rem_s2  <= prod[NW-1:QW];
			word_s2 <= prod[QW-1:0];
			div_s2  <= div_s1;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/wtp_div_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wtp_div_cell
// One restoring division step for both axes; retires one quotient bit.
// ----------------------------------------------------------------------------
module wtp_div_cell #(
	parameter int QW = 14
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     en,
	input  wire wtp_pkg::wtp_ctl_t        ctl_in,
	input  wire logic [wtp_pkg::SW-1:0]   col_rem_in,
	input  wire logic [QW-1:0]            col_word_in,
	input  wire logic [wtp_pkg::SW-1:0]   col_div_in,
	input  wire logic [wtp_pkg::SW-1:0]   row_rem_in,
	input  wire logic [QW-1:0]            row_word_in,
	input  wire logic [wtp_pkg::SW-1:0]   row_div_in,
	output wtp_pkg::wtp_ctl_t             ctl_q,
	output logic      [wtp_pkg::SW-1:0]   col_rem_q,
	output logic      [QW-1:0]            col_word_q,
	output logic      [wtp_pkg::SW-1:0]   col_div_q,
	output logic      [wtp_pkg::SW-1:0]   row_rem_q,
	output logic      [QW-1:0]            row_word_q,
	output logic      [wtp_pkg::SW-1:0]   row_div_q
);
	import wtp_pkg::*;

	logic [SW:0]   col_try, row_try;
	logic [SW:0]   col_sub, row_sub;
	logic          col_ge, row_ge;

	// word: numerator bits still to bring down at the top, quotient bits at the bottom
	always_comb begin
		col_try = {col_rem_in, col_word_in[QW-1]};
		col_sub = col_try - {1'b0, col_div_in};
		col_ge  = col_try >= {1'b0, col_div_in};
		row_try = {row_rem_in, row_word_in[QW-1]};
		row_sub = row_try - {1'b0, row_div_in};
		row_ge  = row_try >= {1'b0, row_div_in};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			col_rem_q  <= col_ge ? col_sub[SW-1:0] : col_try[SW-1:0];
			col_word_q <= QW'({col_word_in, col_ge});
			col_div_q  <= col_div_in;
			row_rem_q  <= row_ge ? row_sub[SW-1:0] : row_try[SW-1:0];
			row_word_q <= QW'({row_word_in, row_ge});
			row_div_q  <= row_div_in;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/window_to_target_pixel_map_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// window_to_target_pixel_map_top
// Maps window points into the render target grid of a letterboxed image.
// ----------------------------------------------------------------------------
// Takes one point per cycle while ready is high and returns one result per
// point, in order. A point inside the image rectangle is scaled edge to
// edge with offset * (target - 1) / (image - 1), truncated; points outside,
// or a zero target size, give hit = 0 with zero coordinates. A point passes
// two front stages, then a chain of one divider cell per quotient bit, then
// the output register. A two-entry output buffer holds a stalled result
// under back-pressure; ready drops only once the spare entry is in use.
// Registers must be written through cfg_we/cfg_index/cfg_data only while no
// point is in flight; the block does not enforce this. Indexes above 5 are
// ignored.
module window_to_target_pixel_map_top #(
	parameter int MAX_DIM = 16384
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [wtp_pkg::RIW-1:0]      cfg_index,
	input  wire logic [wtp_pkg::SW-1:0]       cfg_data,
	wtp_point_if.sink                         point,
	wtp_pixel_if.source                       pixel
);
	import wtp_pkg::*;

	localparam int QW = $clog2(MAX_DIM);

	logic [EW-1:0] image_left_q, image_top_q;
	logic [SW-1:0] image_width_q, image_height_q, target_cols_q, target_rows_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_left_q   <= '0;
			image_top_q    <= '0;
			image_width_q  <= SW'(1);
			image_height_q <= SW'(1);
			target_cols_q  <= SW'(1);
			target_rows_q  <= SW'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_LEFT:   image_left_q   <= cfg_data[EW-1:0];
				REG_IMAGE_TOP:    image_top_q    <= cfg_data[EW-1:0];
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				REG_TARGET_COLS:  target_cols_q  <= cfg_data;
				REG_TARGET_ROWS:  target_rows_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// whole pipeline advances while the spare output entry is free
	logic en;
	logic skid_valid_q;
	logic out_valid_q;

	assign en          = !skid_valid_q;
	assign point.ready = en;

	logic v_s1, v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= point.valid;
			v_s2 <= v_s1;
		end
	end

	logic          col_ok_s2, row_ok_s2;
	wtp_ctl_t      ctl      [QW+1];
	logic [SW-1:0] col_rem  [QW+1];
	logic [QW-1:0] col_word [QW+1];
	logic [SW-1:0] col_div  [QW+1];
	logic [SW-1:0] row_rem  [QW+1];
	logic [QW-1:0] row_word [QW+1];
	logic [SW-1:0] row_div  [QW+1];

	wtp_front #(.MAX_DIM(MAX_DIM)) u_front_col (
		.clk     (clk),
		.en      (en),
		.pos     (point.window_col),
		.origin  (image_left_q),
		.size    (image_width_q),
		.tgt     (target_cols_q),
		.ok_s2   (col_ok_s2),
		.rem_s2  (col_rem[0]),
		.word_s2 (col_word[0]),
		.div_s2  (col_div[0])
	);

	wtp_front #(.MAX_DIM(MAX_DIM)) u_front_row (
		.clk     (clk),
		.en      (en),
		.pos     (point.window_row),
		.origin  (image_top_q),
		.size    (image_height_q),
		.tgt     (target_rows_q),
		.ok_s2   (row_ok_s2),
		.rem_s2  (row_rem[0]),
		.word_s2 (row_word[0]),
		.div_s2  (row_div[0])
	);

	assign ctl[0] = '{valid: v_s2, hit: col_ok_s2 && row_ok_s2};

	for (genvar i = 0; i < QW; i++) begin : g_cell
		wtp_div_cell #(.QW(QW)) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.en          (en),
			.ctl_in      (ctl[i]),
			.col_rem_in  (col_rem[i]),
			.col_word_in (col_word[i]),
			.col_div_in  (col_div[i]),
			.row_rem_in  (row_rem[i]),
			.row_word_in (row_word[i]),
			.row_div_in  (row_div[i]),
			.ctl_q       (ctl[i+1]),
			.col_rem_q   (col_rem[i+1]),
			.col_word_q  (col_word[i+1]),
			.col_div_q   (col_div[i+1]),
			.row_rem_q   (row_rem[i+1]),
			.row_word_q  (row_word[i+1]),
			.row_div_q   (row_div[i+1])
		);
	end

	// after the last cell the word holds the full quotient
	wtp_result_t last_res;
	logic        last_valid;

	always_comb begin
		last_valid   = ctl[QW].valid;
		last_res.hit = ctl[QW].hit;
		last_res.col = ctl[QW].hit ? OW'(col_word[QW]) : '0;
		last_res.row = ctl[QW].hit ? OW'(row_word[QW]) : '0;
	end

	wtp_result_t out_q, skid_q;
	logic        load_out, load_skid, out_from_skid;

	always_comb begin
		out_from_skid = skid_valid_q && pixel.ready;
		load_out      = !skid_valid_q && last_valid && (!out_valid_q || pixel.ready);
		load_skid     = !skid_valid_q && last_valid && out_valid_q && !pixel.ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_from_skid) begin
				skid_valid_q <= 1'b0;
			end else if (load_skid) begin
				skid_valid_q <= 1'b1;
			end
			if (!skid_valid_q && (!out_valid_q || pixel.ready)) begin
				out_valid_q <= last_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_from_skid) begin
			out_q <= skid_q;
		end else if (load_out) begin
			out_q <= last_res;
		end
		if (load_skid) begin
			skid_q <= last_res;
		end
	end

	assign pixel.valid      = out_valid_q;
	assign pixel.hit        = out_q.hit;
	assign pixel.target_col = out_q.col;
	assign pixel.target_row = out_q.row;

endmodule
`default_nettype wire

// ===== tb/sv/tb_window_to_target_pixel_map_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_window_to_target_pixel_map_top
// Self-checking bench for the window to target pixel map: directed corner
// points, then random points under several idle mixes and a long output hold,
// each result checked against an in-bench edge-to-edge scaling predictor.
// ----------------------------------------------------------------------------
module tb_window_to_target_pixel_map_top;
	import wtp_pkg::*;

	localparam int MAX_DIM = 16384;
	localparam logic [RIW-1:0] REG_UNMAPPED_A = 3'd6;
	localparam logic [RIW-1:0] REG_UNMAPPED_B = 3'd7;

	logic           clk;
	logic           arst_n;
	logic           cfg_we;
	logic [RIW-1:0] cfg_index;
	logic [SW-1:0]  cfg_data;

	wtp_point_if point_ch();
	wtp_pixel_if pixel_ch();

	window_to_target_pixel_map_top #(
		.MAX_DIM(MAX_DIM)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.point    (point_ch),
		.pixel    (pixel_ch)
	);

	// register copies as the block should hold them
	logic [EW-1:0] img_left;
	logic [EW-1:0] img_top;
	logic [SW-1:0] img_w;
	logic [SW-1:0] img_h;
	logic [SW-1:0] tgt_cols;
	logic [SW-1:0] tgt_rows;

	wtp_result_t pending_pixels[$];
	wtp_result_t want;

	int src_idle_pct;
	int sink_stall_pct;
	int hold_len;
	int errors;
	int points_in;
	int pixels_out;
	int hits_seen;
	int input_stalls;
	int reg_writes;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#1600000;
		$display("status: fail");
		$finish;
	end

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------
	function automatic logic scale_axis(input longint pos, input longint edge_px,
			input longint size, input longint tgt, output logic [OW-1:0] px);
		longint ofs;
		longint sz;
		longint t;
		longint v;
		ofs = pos - edge_px;
		sz  = (size < 1) ? 1 : size;
		t   = (tgt > MAX_DIM) ? MAX_DIM : tgt;
		v   = 0;
		px  = '0;
		if (ofs < 0 || ofs >= sz)
			return 1'b0;
		if (sz > 1 && t > 1)
			v = ofs * (t - 1) / (sz - 1);
		if (v > t - 1)
			v = t - 1;
		px = v[OW-1:0];
		return 1'b1;
	endfunction

	function automatic wtp_result_t predict_pixel(input logic signed [CW-1:0] col,
			input logic signed [CW-1:0] row);
		wtp_result_t r;
		logic [OW-1:0] tx;
		logic [OW-1:0] ty;
		logic hx;
		logic hy;
		r = '0;
		if (tgt_cols != 0 && tgt_rows != 0) begin
			hx = scale_axis(longint'(col), longint'(img_left), longint'(img_w),
				longint'(tgt_cols), tx);
			hy = scale_axis(longint'(row), longint'(img_top), longint'(img_h),
				longint'(tgt_rows), ty);
			if (hx && hy) begin
				r.hit = 1'b1;
				r.col = tx;
				r.row = ty;
			end
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// monitors and checker
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string what, input longint got, input longint exp_val);
		errors++;
		if (errors <= 40)
			$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, exp_val);
	endtask

	always @(posedge clk) begin
		if (arst_n && point_ch.valid) begin
			if (point_ch.ready) begin
				pending_pixels.push_back(predict_pixel(point_ch.window_col,
					point_ch.window_row));
				points_in++;
			end else begin
				input_stalls++;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && pixel_ch.valid && pixel_ch.ready) begin
			pixels_out++;
			if (pixel_ch.hit)
				hits_seen++;
			if (pending_pixels.size() == 0) begin
				report_mismatch("pixel beat with nothing pending",
					longint'(pixel_ch.hit), longint'(0));
			end else begin
				want = pending_pixels.pop_front();
				if (pixel_ch.hit !== want.hit)
					report_mismatch("hit", longint'(pixel_ch.hit), longint'(want.hit));
				if (pixel_ch.target_col !== want.col)
					report_mismatch("target_col", longint'(pixel_ch.target_col),
						longint'(want.col));
				if (pixel_ch.target_row !== want.row)
					report_mismatch("target_row", longint'(pixel_ch.target_row),
						longint'(want.row));
			end
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	initial begin : receiver
		int n;
		pixel_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_len > 0) begin
				n = hold_len;
				hold_len = 0;
				pixel_ch.ready <= 1'b0;
				repeat (n - 1) @(posedge clk);
			end else begin
				pixel_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	// ------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------
	task automatic send_point(input logic [CW-1:0] col, input logic [CW-1:0] row);
		if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			point_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		point_ch.valid      <= 1'b1;
		point_ch.window_col <= col;
		point_ch.window_row <= row;
		@(posedge clk);
		while (!point_ch.ready) @(posedge clk);
	endtask

	// stop offering points and let every pending pixel come back
	task automatic drain;
		point_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [RIW-1:0] idx, input logic [SW-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		reg_writes++;
		case (idx)
			REG_IMAGE_LEFT:   img_left = data[EW-1:0];
			REG_IMAGE_TOP:    img_top  = data[EW-1:0];
			REG_IMAGE_WIDTH:  img_w    = data;
			REG_IMAGE_HEIGHT: img_h    = data;
			REG_TARGET_COLS:  tgt_cols = data;
			REG_TARGET_ROWS:  tgt_rows = data;
			default: ;
		endcase
	endtask

	task automatic end_writes;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_config(input logic [SW-1:0] left, input logic [SW-1:0] top,
			input logic [SW-1:0] w, input logic [SW-1:0] h,
			input logic [SW-1:0] cols, input logic [SW-1:0] rows);
		drain();
		write_reg(REG_IMAGE_LEFT, left);
		write_reg(REG_IMAGE_TOP, top);
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		write_reg(REG_TARGET_COLS, cols);
		write_reg(REG_TARGET_ROWS, rows);
		end_writes();
	endtask

	// ------------------------------------------------------------------
	// random pickers
	// ------------------------------------------------------------------
	function automatic logic [SW-1:0] pick_edge;
		case ($urandom_range(4))
			0: return 15'd0;
			1: return 15'd16383;
			2: return SW'($urandom_range(0, 200));
			3: return SW'($urandom_range(0, 16383));
			default: return SW'($urandom_range(0, 32767));  // upper bit must be dropped
		endcase
	endfunction

	function automatic logic [SW-1:0] pick_extent;
		case ($urandom_range(9))
			0: return 15'd0;
			1: return 15'd1;
			2: return 15'd2;
			3: return SW'($urandom_range(3, 64));
			4: return SW'($urandom_range(65, 16383));
			5: return 15'd16384;
			6: return SW'($urandom_range(16385, 32767));
			7: return 15'd32767;
			default: return SW'($urandom_range(1, 2000));
		endcase
	endfunction

	// mostly inside the rectangle, some on its border, some anywhere
	function automatic logic [CW-1:0] pick_coord(input longint edge_px, input longint size);
		longint sz;
		longint c;
		int sel;
		sz  = (size < 1) ? 1 : size;
		sel = $urandom_range(99);
		if (sel < 70) begin
			c = edge_px + longint'($urandom_range(0, 32'(sz - 1)));
			if (c > 32767)
				c = edge_px + longint'($urandom_range(0, 32'(32767 - edge_px)));
		end else if (sel < 85) begin
			case ($urandom_range(3))
				0: c = edge_px - 1;
				1: c = edge_px;
				2: c = edge_px + sz - 1;
				default: c = edge_px + sz;
			endcase
		end else begin
			c = longint'($urandom_range(0, 65535));
		end
		return c[CW-1:0];
	endfunction

	task automatic send_random_point;
		send_point(pick_coord(longint'(img_left), longint'(img_w)),
			pick_coord(longint'(img_top), longint'(img_h)));
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	task automatic test_reset_state;
		send_point(16'd0, 16'd0);
		send_point(16'd1, 16'd0);
		send_point(16'hFFFF, 16'hFFFF);
		send_point(16'h8000, 16'h7FFF);
	endtask

	task automatic test_rectangle_edges;
		apply_config(15'd100, 15'd50, 15'd640, 15'd480, 15'd1920, 15'd1080);
		send_point(16'd100, 16'd50);
		send_point(16'd739, 16'd529);
		send_point(16'd420, 16'd290);
		send_point(16'd99, 16'd50);
		send_point(16'd740, 16'd50);
		send_point(16'd100, 16'd49);
		send_point(16'd100, 16'd530);
	endtask

	task automatic test_zero_target;
		apply_config(15'd0, 15'd0, 15'd64, 15'd64, 15'd0, 15'd64);
		send_point(16'd10, 16'd10);
		apply_config(15'd0, 15'd0, 15'd64, 15'd64, 15'd64, 15'd0);
		send_point(16'd10, 16'd10);
	endtask

	// zero image size acts as one; one-pixel image or target maps to 0
	task automatic test_degenerate_sizes;
		apply_config(15'd5, 15'd7, 15'd0, 15'd1, 15'd300, 15'd300);
		send_point(16'd5, 16'd7);
		send_point(16'd6, 16'd7);
		apply_config(15'd5, 15'd7, 15'd200, 15'd200, 15'd1, 15'd2);
		send_point(16'd204, 16'd204);
	endtask

	// target above MAX_DIM saturates; largest image and coordinates
	task automatic test_oversize_target;
		apply_config(15'd0, 15'd0, 15'd32767, 15'd16384, 15'd32767, 15'd16384);
		send_point(16'd32766, 16'd16383);
		send_point(16'h7FFF, 16'd8192);
		send_point(16'd12345, 16'd0);
	endtask

	// upper bit of an edge is dropped; indexes past the last register do nothing
	task automatic test_register_decode;
		apply_config(15'h7FFF, 15'h4000, 15'd2, 15'd2, 15'd16384, 15'd16384);
		drain();
		write_reg(REG_UNMAPPED_A, 15'h7FFF);
		write_reg(REG_UNMAPPED_B, 15'd0);
		end_writes();
		send_point(16'd16384, 16'd1);
		send_point(16'd16383, 16'd0);
	endtask

	task automatic test_random_phase(input int n_points, input int src_pct,
			input int sink_pct);
		drain();
		src_idle_pct   = src_pct;
		sink_stall_pct = sink_pct;
		for (int i = 0; i < n_points; i++) begin
			if (i % 35 == 0)
				apply_config(pick_edge(), pick_edge(), pick_extent(), pick_extent(),
					pick_extent(), pick_extent());
			send_random_point();
		end
	endtask

	// hold the output off long enough that the input must stall
	task automatic test_output_backpressure;
		apply_config(15'd20, 15'd20, 15'd1000, 15'd700, 15'd4096, 15'd2160);
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		hold_len       = 300;
		for (int i = 0; i < 80; i++)
			send_random_point();
	endtask

	initial begin
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = REG_IMAGE_LEFT;
		cfg_data            = '0;
		point_ch.valid      = 1'b0;
		point_ch.window_col = '0;
		point_ch.window_row = '0;
		img_left            = '0;
		img_top             = '0;
		img_w               = 15'd1;
		img_h               = 15'd1;
		tgt_cols            = 15'd1;
		tgt_rows            = 15'd1;
		src_idle_pct        = 0;
		sink_stall_pct      = 0;
		hold_len            = 0;
		errors              = 0;
		points_in           = 0;
		pixels_out          = 0;
		hits_seen           = 0;
		input_stalls        = 0;
		reg_writes          = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_rectangle_edges();
		test_zero_target();
		test_degenerate_sizes();
		test_oversize_target();
		test_register_decode();
		test_random_phase(190, 0, 0);
		test_random_phase(190, 63, 0);
		test_random_phase(190, 0, 63);
		test_random_phase(180, 19, 19);
		test_output_backpressure();

		point_ch.valid <= 1'b0;
		for (int w = 0; w < 20000 && pending_pixels.size() != 0; w++)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (pending_pixels.size() != 0)
			report_mismatch("pixels never returned", longint'(0),
				longint'(pending_pixels.size()));

		$display("covered %0d points, %0d pixels checked (%0d hits), %0d register writes",
			points_in, pixels_out, hits_seen, reg_writes);
		$display("idle mixes: none, source, sink, both; input stalled %0d cycles",
			input_stalls);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/wtp_pkg.sv
hdl/wtp_if.sv
hdl/wtp_front.sv
hdl/wtp_div_cell.sv
hdl/window_to_target_pixel_map_top.sv
tb/sv/tb_window_to_target_pixel_map_top.sv
